// ----- design/necir_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// necir_pkg
// Shared widths, reset targets, register indexes and result codes of the
// NEC infrared frame decoder.
// ----------------------------------------------------------------------------
package necir_pkg;

  // Width of every duration field and timing target
  localparam int DURATION_WIDTH = 15;

  // Symbol counter: counts up to the saturation value
  localparam int COUNT_WIDTH  = 6;
  localparam int COUNT_SAT    = 34;
  localparam int DATA_SYMBOLS = 32;
  localparam int DATA_WIDTH   = 32;
  localparam int BITPOS_WIDTH = 5;
  localparam int BYTE_WIDTH   = 8;

  // Configuration port
  localparam int CFG_INDEX_WIDTH = 3;

  localparam logic [CFG_INDEX_WIDTH-1:0] REG_LEAD_MARK    = 3'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_LEAD_SPACE   = 3'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_REPEAT_SPACE = 3'd2;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_BIT_MARK     = 3'd3;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_ONE_SPACE    = 3'd4;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_ZERO_SPACE   = 3'd5;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_REPORT_EN    = 3'd6;

  // Reset targets in ticks, cut to the duration width
  localparam logic [DURATION_WIDTH-1:0] RST_LEAD_MARK    = DURATION_WIDTH'(9000);
  localparam logic [DURATION_WIDTH-1:0] RST_LEAD_SPACE   = DURATION_WIDTH'(4500);
  localparam logic [DURATION_WIDTH-1:0] RST_REPEAT_SPACE = DURATION_WIDTH'(2250);
  localparam logic [DURATION_WIDTH-1:0] RST_BIT_MARK     = DURATION_WIDTH'(560);
  localparam logic [DURATION_WIDTH-1:0] RST_ONE_SPACE    = DURATION_WIDTH'(1690);
  localparam logic [DURATION_WIDTH-1:0] RST_ZERO_SPACE   = DURATION_WIDTH'(560);

  localparam logic [BYTE_WIDTH-1:0] BYTE_ALL = 8'hFF;

  // Frame status codes
  typedef enum logic [1:0] {
    ST_DECODED = 2'd0,
    ST_REPEAT  = 2'd1,
    ST_ERROR   = 2'd2,
    ST_INVERSE = 2'd3
  } status_t;

  // Timing matches of one symbol
  typedef struct packed {
    logic lead_mark;
    logic lead_space;
    logic repeat_space;
    logic bit_mark;
    logic one_space;
    logic zero_space;
  } match_t;

  // One frame result
  typedef struct packed {
    status_t                status;
    logic [BYTE_WIDTH-1:0]  address;
    logic [BYTE_WIDTH-1:0]  command;
  } result_t;

endpackage

// ----- design/necir_match.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// necir_match
// Window compare: a duration hits its target when it lies strictly between
// target minus and target plus a quarter of the target.
// ----------------------------------------------------------------------------
module necir_match (
  input  logic [necir_pkg::DURATION_WIDTH-1:0] duration,
  input  logic [necir_pkg::DURATION_WIDTH-1:0] target,
  output logic                                 hit
);

  logic [necir_pkg::DURATION_WIDTH:0] quarter;
  logic [necir_pkg::DURATION_WIDTH:0] low_bound;
  logic [necir_pkg::DURATION_WIDTH:0] high_bound;
  logic [necir_pkg::DURATION_WIDTH:0] dur_ext;

  // Widen by one bit so the upper bound cannot wrap
  assign quarter    = {3'b000, target[necir_pkg::DURATION_WIDTH-1:2]};
  assign dur_ext    = {1'b0, duration};
  assign low_bound  = {1'b0, target} - quarter;
  assign high_bound = {1'b0, target} + quarter;
  assign hit        = (dur_ext > low_bound) && (dur_ext < high_bound);

endmodule

// ----- design/necir_frame.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// necir_frame
// Frame state: symbol counter, collected data bits and timing flags, and
// the verdict given on the last symbol of a frame.
// ----------------------------------------------------------------------------
module necir_frame (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       advance,
  input  necir_pkg::match_t          match,
  input  logic                       last,
  output necir_pkg::result_t         result
);

  logic [necir_pkg::COUNT_WIDTH-1:0]  symbol_count;
  logic [necir_pkg::COUNT_WIDTH-1:0]  symbol_count_next;
  logic [necir_pkg::DATA_WIDTH-1:0]   data_bits;
  logic [necir_pkg::DATA_WIDTH-1:0]   data_bits_next;
  logic                               lead_full_ok;
  logic                               lead_full_ok_next;
  logic                               lead_repeat_ok;
  logic                               lead_repeat_ok_next;
  logic                               bit_error;
  logic                               bit_error_next;
  logic [necir_pkg::COUNT_WIDTH-1:0]  bit_index;
  logic [necir_pkg::BITPOS_WIDTH-1:0] bit_pos;
  logic [necir_pkg::BYTE_WIDTH-1:0]   addr_byte;
  logic [necir_pkg::BYTE_WIDTH-1:0]   addr_inv;
  logic [necir_pkg::BYTE_WIDTH-1:0]   cmd_byte;
  logic [necir_pkg::BYTE_WIDTH-1:0]   cmd_inv;

  assign bit_index = symbol_count - necir_pkg::COUNT_WIDTH'(1);
  assign bit_pos   = bit_index[necir_pkg::BITPOS_WIDTH-1:0];

  // Update the frame state with this symbol
  always_comb begin
    data_bits_next      = data_bits;
    lead_full_ok_next   = lead_full_ok;
    lead_repeat_ok_next = lead_repeat_ok;
    bit_error_next      = bit_error;
    if (symbol_count == '0) begin
      lead_full_ok_next   = match.lead_mark && match.lead_space;
      lead_repeat_ok_next = match.lead_mark && match.repeat_space;
    end else if (symbol_count <= necir_pkg::COUNT_WIDTH'(necir_pkg::DATA_SYMBOLS)) begin
      priority if (!match.bit_mark) begin
        bit_error_next = 1'b1;
      end else if (match.one_space) begin
        data_bits_next = data_bits | (necir_pkg::DATA_WIDTH'(1) << bit_pos);
      end else if (!match.zero_space) begin
        bit_error_next = 1'b1;
      end else begin
        // a clean zero bit leaves the word as it is
      end
    end
    if (symbol_count < necir_pkg::COUNT_WIDTH'(necir_pkg::COUNT_SAT)) begin
      symbol_count_next = symbol_count + necir_pkg::COUNT_WIDTH'(1);
    end else begin
      symbol_count_next = symbol_count;
    end
  end

  // Split the collected word into bytes
  assign addr_byte = data_bits_next[7:0];
  assign addr_inv  = data_bits_next[15:8];
  assign cmd_byte  = data_bits_next[23:16];
  assign cmd_inv   = data_bits_next[31:24];

  // Judge the frame: repeat first, then length and timing, then inverses
  always_comb begin
    result.address = '0;
    result.command = '0;
    priority if (symbol_count_next >= necir_pkg::COUNT_WIDTH'(2) && lead_repeat_ok_next) begin
      result.status = necir_pkg::ST_REPEAT;
    end else if (symbol_count_next < necir_pkg::COUNT_WIDTH'(necir_pkg::DATA_SYMBOLS + 1)
                 || !lead_full_ok_next || bit_error_next) begin
      result.status = necir_pkg::ST_ERROR;
    end else if ((addr_byte ^ addr_inv) != necir_pkg::BYTE_ALL
                 || (cmd_byte ^ cmd_inv) != necir_pkg::BYTE_ALL) begin
      result.status = necir_pkg::ST_INVERSE;
    end else begin
      result.status  = necir_pkg::ST_DECODED;
      result.address = addr_byte;
      result.command = cmd_byte;
    end
  end

  // Advance the state; drop it after the last symbol of a frame
  always_ff @(posedge clk) begin
    if (rst) begin
      symbol_count   <= '0;
      data_bits      <= '0;
      lead_full_ok   <= 1'b0;
      lead_repeat_ok <= 1'b0;
      bit_error      <= 1'b0;
    end else if (advance) begin
      if (last) begin
        symbol_count   <= '0;
        data_bits      <= '0;
        lead_full_ok   <= 1'b0;
        lead_repeat_ok <= 1'b0;
        bit_error      <= 1'b0;
      end else begin
        symbol_count   <= symbol_count_next;
        data_bits      <= data_bits_next;
        lead_full_ok   <= lead_full_ok_next;
        lead_repeat_ok <= lead_repeat_ok_next;
        bit_error      <= bit_error_next;
      end
    end
  end

endmodule

// ----- design/nec_ir_frame_decoder.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nec_ir_frame_decoder
// NEC infrared frame decoder: judges symbols of mark and space durations and
// gives one status, address and command per frame.
// ----------------------------------------------------------------------------
// Takes one symbol per clock while not stalled. A symbol is registered on
// arrival, then checked against the six timing windows and folded into the
// frame state as it leaves the symbol register; the verdict of a frame is
// loaded into the output register at that same edge and offered from there.
// A result is only produced when report_enable is set; otherwise frames are
// judged and dropped. The input stalls only while a finished result waits in
// the output register and the registered symbol would produce another. The
// user must write configuration while no symbol is in flight; the block does
// not enforce this. Index 6 is report_enable, indexes past it are ignored.
// ----------------------------------------------------------------------------
module nec_ir_frame_decoder (
  input  logic                                  clk,
  input  logic                                  rst,
  // configuration
  input  logic                                  cfg_write,
  input  logic [necir_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [necir_pkg::DURATION_WIDTH-1:0]  cfg_data,
  // symbol requests
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [necir_pkg::DURATION_WIDTH-1:0]  mark_ticks,
  input  logic [necir_pkg::DURATION_WIDTH-1:0]  space_ticks,
  input  logic                                  frame_end,
  // result requests
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [1:0]                            status,
  output logic [necir_pkg::BYTE_WIDTH-1:0]      address,
  output logic [necir_pkg::BYTE_WIDTH-1:0]      command
);

  logic [necir_pkg::DURATION_WIDTH-1:0] lead_mark_ticks;
  logic [necir_pkg::DURATION_WIDTH-1:0] lead_space_ticks;
  logic [necir_pkg::DURATION_WIDTH-1:0] repeat_space_ticks;
  logic [necir_pkg::DURATION_WIDTH-1:0] bit_mark_ticks;
  logic [necir_pkg::DURATION_WIDTH-1:0] one_space_ticks;
  logic [necir_pkg::DURATION_WIDTH-1:0] zero_space_ticks;
  logic                                 report_enable;

  logic                                 sym_valid;
  logic [necir_pkg::DURATION_WIDTH-1:0] sym_mark;
  logic [necir_pkg::DURATION_WIDTH-1:0] sym_space;
  logic                                 sym_last;

  logic                                 sym_emits;
  logic                                 sym_advance;
  logic                                 sym_fire;
  logic                                 in_accept;
  logic                                 out_take;

  necir_pkg::match_t                    match;
  necir_pkg::result_t                   frame_result;
  necir_pkg::result_t                   out_result;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      lead_mark_ticks    <= necir_pkg::RST_LEAD_MARK;
      lead_space_ticks   <= necir_pkg::RST_LEAD_SPACE;
      repeat_space_ticks <= necir_pkg::RST_REPEAT_SPACE;
      bit_mark_ticks     <= necir_pkg::RST_BIT_MARK;
      one_space_ticks    <= necir_pkg::RST_ONE_SPACE;
      zero_space_ticks   <= necir_pkg::RST_ZERO_SPACE;
      report_enable      <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        necir_pkg::REG_LEAD_MARK:    lead_mark_ticks    <= cfg_data;
        necir_pkg::REG_LEAD_SPACE:   lead_space_ticks   <= cfg_data;
        necir_pkg::REG_REPEAT_SPACE: repeat_space_ticks <= cfg_data;
        necir_pkg::REG_BIT_MARK:     bit_mark_ticks     <= cfg_data;
        necir_pkg::REG_ONE_SPACE:    one_space_ticks    <= cfg_data;
        necir_pkg::REG_ZERO_SPACE:   zero_space_ticks   <= cfg_data;
        necir_pkg::REG_REPORT_EN:    report_enable      <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // Flow control: the registered symbol moves on unless its result has
  // nowhere to go
  assign out_take    = out_valid && !out_stall;
  assign sym_emits   = sym_last && report_enable;
  assign sym_advance = !sym_emits || !out_valid || !out_stall;
  assign sym_fire    = sym_valid && sym_advance;
  assign in_stall    = sym_valid && !sym_advance;
  assign in_accept   = in_valid && !in_stall;

  // Symbol register
  always_ff @(posedge clk) begin
    if (rst) begin
      sym_valid <= 1'b0;
    end else if (in_accept) begin
      sym_valid <= 1'b1;
    end else if (sym_fire) begin
      sym_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      sym_mark  <= mark_ticks;
      sym_space <= space_ticks;
      sym_last  <= frame_end;
    end
  end

  // Timing windows
  necir_match u_lead_mark (
    .duration (sym_mark),
    .target   (lead_mark_ticks),
    .hit      (match.lead_mark)
  );

  necir_match u_lead_space (
    .duration (sym_space),
    .target   (lead_space_ticks),
    .hit      (match.lead_space)
  );

  necir_match u_repeat_space (
    .duration (sym_space),
    .target   (repeat_space_ticks),
    .hit      (match.repeat_space)
  );

  necir_match u_bit_mark (
    .duration (sym_mark),
    .target   (bit_mark_ticks),
    .hit      (match.bit_mark)
  );

  necir_match u_one_space (
    .duration (sym_space),
    .target   (one_space_ticks),
    .hit      (match.one_space)
  );

  necir_match u_zero_space (
    .duration (sym_space),
    .target   (zero_space_ticks),
    .hit      (match.zero_space)
  );

  // Frame state and verdict
  necir_frame u_frame (
    .clk     (clk),
    .rst     (rst),
    .advance (sym_fire),
    .match   (match),
    .last    (sym_last),
    .result  (frame_result)
  );

  // Output register: load a verdict, hold it until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (sym_fire && sym_emits) begin
      out_valid <= 1'b1;
    end else if (out_take) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (sym_fire && sym_emits) begin
      out_result <= frame_result;
    end
  end

  assign status  = out_result.status;
  assign address = out_result.address;
  assign command = out_result.command;

endmodule
